>>> hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// expects clk and rst_n in the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rsws_pkg.sv
// package for the record stack with search: payload structs, codes, control types
// no dependencies
`timescale 1ns / 1ps

package rsws_pkg;

    localparam int DEPTH_DEF = 16;

    localparam logic [2:0] REQ_PUSH   = 3'd0;
    localparam logic [2:0] REQ_POP    = 3'd1;
    localparam logic [2:0] REQ_SEARCH = 3'd2;
    localparam logic [2:0] REQ_PEEK   = 3'd3;
    localparam logic [2:0] REQ_LIST   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNDER    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_OVER     = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [63:0]        key_name_low;
        logic [63:0]        key_name_mid;
        logic [31:0]        key_name_high;
        logic signed [31:0] car_model;
        logic [31:0]        car_price_bits;
    } rsws_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [63:0]        out_name_low;
        logic [63:0]        out_name_mid;
        logic [31:0]        out_name_high;
        logic signed [31:0] out_model;
        logic [31:0]        out_price_bits;
        logic               last;
    } rsws_out_t;

    typedef struct packed {
        logic [63:0] name_low;
        logic [63:0] name_mid;
        logic [31:0] name_high;
        logic [31:0] model;
        logic [31:0] price;
    } rsws_entry_t;

    typedef struct packed {
        logic       load_req;
        logic       push_wr;
        logic       rd_en;
        logic       idx_load_top;
        logic       idx_dec;
        logic       cnt_dec;
        logic       out_load_status;
        logic       out_load_entry;
        logic       out_last;
        logic [1:0] out_status;
    } rsws_cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       empty;
        logic       full;
        logic       match;
        logic       idx_zero;
    } rsws_sts_t;

endpackage

>>> hw/rtl/rsws_dp.sv
// datapath: record memory, count, scan index, request and result registers
// depends on rsws_pkg
`timescale 1ns / 1ps

module rsws_dp
    import rsws_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  rsws_in_t  req,
    input  rsws_cmd_t cmd,
    output rsws_sts_t sts,
    output rsws_out_t rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rsws_entry_t mem [DEPTH];
    rsws_entry_t rdata_reg;
    rsws_in_t    req_reg;
    rsws_out_t   rsp_reg;
    rsws_out_t   rsp_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic [CW-1:0] top;
    rsws_entry_t   wdata;

    assign top = count_reg - CW'(1);

    assign wdata.name_low  = req_reg.key_name_low;
    assign wdata.name_mid  = req_reg.key_name_mid;
    assign wdata.name_high = req_reg.key_name_high;
    assign wdata.model     = req_reg.car_model;
    assign wdata.price     = req_reg.car_price_bits;

    always_ff @(posedge clk)
    begin
        if (cmd.push_wr)
        begin
            mem[count_reg[AW-1:0]] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push_wr)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = top;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_load_top)
        begin
            idx_next = top[AW-1:0];
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - AW'(1);
        end
    end

    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.out_load_status)
        begin
            rsp_next = '0;
            rsp_next.status = cmd.out_status;
            rsp_next.last = 1'b1;
        end
        else if (cmd.out_load_entry)
        begin
            rsp_next.status = ST_OK;
            rsp_next.out_name_low = rdata_reg.name_low;
            rsp_next.out_name_mid = rdata_reg.name_mid;
            rsp_next.out_name_high = rdata_reg.name_high;
            rsp_next.out_model = rdata_reg.model;
            rsp_next.out_price_bits = rdata_reg.price;
            rsp_next.last = cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        rsp_reg <= rsp_next;
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
    end

    assign sts.req_type = req_reg.req_type;
    assign sts.empty    = (count_reg == '0);
    assign sts.full     = (count_reg == CW'(DEPTH));
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.match    = (rdata_reg.name_low == req_reg.key_name_low)
                        && (rdata_reg.name_mid == req_reg.key_name_mid)
                        && (rdata_reg.name_high == req_reg.key_name_high);

    assign rsp = rsp_reg;

endmodule

>>> hw/rtl/rsws_ctrl.sv
// controller state machine: sequences decode, memory reads, scan and result handoff
// depends on rsws_pkg
`timescale 1ns / 1ps

module rsws_ctrl
    import rsws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  rsws_sts_t sts,
    output rsws_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.req_type)
                    REQ_PUSH:
                    begin
                        cmd.out_load_status = 1'b1;
                        if (sts.full)
                        begin
                            cmd.out_status = ST_OVER;
                        end
                        else
                        begin
                            cmd.out_status = ST_OK;
                            cmd.push_wr = 1'b1;
                        end
                        state_next = S_OUT;
                    end
                    REQ_POP, REQ_SEARCH, REQ_PEEK, REQ_LIST:
                    begin
                        if (sts.empty)
                        begin
                            cmd.out_load_status = 1'b1;
                            cmd.out_status = ST_UNDER;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            cmd.idx_load_top = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.rd_en = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                unique case (sts.req_type)
                    REQ_SEARCH:
                    begin
                        if (sts.match)
                        begin
                            cmd.out_load_entry = 1'b1;
                            cmd.out_last = 1'b1;
                            state_next = S_OUT;
                        end
                        else if (sts.idx_zero)
                        begin
                            cmd.out_load_status = 1'b1;
                            cmd.out_status = ST_NOTFOUND;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            cmd.idx_dec = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    REQ_LIST:
                    begin
                        cmd.out_load_entry = 1'b1;
                        cmd.out_last = sts.idx_zero;
                        state_next = S_OUT;
                    end
                    REQ_POP:
                    begin
                        cmd.out_load_entry = 1'b1;
                        cmd.out_last = 1'b1;
                        cmd.cnt_dec = 1'b1;
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        cmd.out_load_entry = 1'b1;
                        cmd.out_last = 1'b1;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_OUT:
            begin
                if (rsp_ready)
                begin
                    if (sts.req_type == REQ_LIST && !sts.idx_zero)
                    begin
                        cmd.idx_dec = 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);

endmodule

>>> hw/rtl/record_stack_with_search.sv
// top level of the record stack with search: joins controller and datapath
// depends on rsws_pkg, rsws_ctrl, rsws_dp
//
//   channel | signals                        | word
//   req     | req_valid, req_ready, req      | rsws_in_t, one request
//   rsp     | rsp_valid, rsp_ready, rsp      | rsws_out_t, one result record
//
// one request at a time; req_ready is high only while the controller is idle
// push, overflow and underflow: result word registered in the decode state after the request is captured
// pop and peek: result word follows decode, read and check states (one registered memory read)
// search: a read and a check state per entry scanned from the top; list: read, check and output per record, plus stall
// reset clears the count and the controller state only; record memory needs no clearing pass
`timescale 1ns / 1ps

module record_stack_with_search
    import rsws_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  rsws_in_t  req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsws_out_t rsp
);

    rsws_cmd_t cmd;
    rsws_sts_t sts;

    rsws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rsws_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

>>> hw/rtl/rsws_checker.sv
// port-level checker for the record stack with search, bound to the top level
// depends on rsws_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsws_checker
    import rsws_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input rsws_in_t  req,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsws_out_t rsp
);

    logic err_status;

    assign err_status = rsp_valid && (rsp.status != ST_OK);

    `CHK_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req), "waiting request word changed")
    `CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled word changed")
    `CHK_IMPLIES(a_one_at_a_time, rsp_valid, !req_ready, "request taken while result pending")
    `CHK_IMPLIES(a_err_last, err_status, rsp.last, "error word not marked last")
    `CHK_IMPLIES(a_err_zero, err_status, rsp.out_name_low == '0 && rsp.out_model == '0, "error word has data")

endmodule

bind record_stack_with_search rsws_checker u_rsws_checker (.*);

>>> dv/tb.sv
// testbench for record_stack_with_search: directed table then random requests,
// replies checked against table replies or a local stack predictor; depends on rsws_pkg and the rtl
`timescale 1ns / 1ps

module tb;
    import rsws_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int RANDOM_REQS = 85;
    localparam int LATENCY     = 2 * DEPTH + 8;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 70;

    localparam logic [2:0] REQ_BAD_LO = 3'd5;
    localparam logic [2:0] REQ_BAD_HI = 3'd7;

    localparam logic [159:0] NAME_ONES    = '1;
    localparam logic [159:0] NAME_ZERO    = '0;
    localparam logic [159:0] NAME_GAP     = 160'h44_4300_4241;
    localparam logic [159:0] NAME_GAP_ALT = NAME_GAP | {8'h01, 152'h0};
    localparam logic [159:0] NAME_GAP_CUT = 160'h4241;

    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_t;

    typedef struct {
        rsws_in_t  word;
        int        reps;
        bit        fresh;
        bit        typed;
        rsws_out_t reply;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    rsws_in_t  req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsws_out_t rsp;

    rsws_entry_t  stack_mem [DEPTH];
    int           stack_count = 0;
    rsws_out_t    expected_replies[$];
    rsws_out_t    want;
    stim_row_t    directed[$];
    logic [159:0] name_pool [8];
    int           mismatches = 0;
    int           replies_seen = 0;
    int           burst_left = 0;

    record_stack_with_search #(.DEPTH(DEPTH)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic rsws_out_t status_reply(input logic [1:0] st);
        rsws_out_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic rsws_out_t entry_reply(input rsws_entry_t e, input logic fin);
        rsws_out_t r;
        r.status = ST_OK;
        r.out_name_low = e.name_low;
        r.out_name_mid = e.name_mid;
        r.out_name_high = e.name_high;
        r.out_model = e.model;
        r.out_price_bits = e.price;
        r.last = fin;
        return r;
    endfunction

    function automatic rsws_in_t make_req(input logic [2:0] t, input logic [159:0] n,
                                          input logic [31:0] m, input logic [31:0] p);
        rsws_in_t w;
        w.req_type = t;
        w.key_name_low = n[63:0];
        w.key_name_mid = n[127:64];
        w.key_name_high = n[159:128];
        w.car_model = m;
        w.car_price_bits = p;
        return w;
    endfunction

    function automatic logic [159:0] random_name();
        logic [159:0] n;
        int len;
        int b;
        n = {$urandom, $urandom, $urandom, $urandom, $urandom};
        len = $urandom_range(0, 20);
        for (b = len; b < 20; b++)
            n[b*8 +: 8] = 8'h00;
        // stray byte inside the zero padding
        if (len < 20 && $urandom_range(0, 3) == 0)
            n[$urandom_range(len, 19)*8 +: 8] = 8'h5a;
        return n;
    endfunction

    task automatic predict_replies(input rsws_in_t w, input bit keep);
        rsws_out_t   got[$];
        rsws_entry_t e;
        int          k;
        bit          hit;
        if (w.req_type > REQ_LIST)
            return;
        if (w.req_type == REQ_PUSH)
        begin
            if (stack_count >= DEPTH)
                got.push_back(status_reply(ST_OVER));
            else
            begin
                e.name_low = w.key_name_low;
                e.name_mid = w.key_name_mid;
                e.name_high = w.key_name_high;
                e.model = w.car_model;
                e.price = w.car_price_bits;
                stack_mem[stack_count] = e;
                stack_count++;
                got.push_back(status_reply(ST_OK));
            end
        end
        else if (stack_count == 0)
            got.push_back(status_reply(ST_UNDER));
        else
        begin
            case (w.req_type)
                REQ_POP:
                begin
                    got.push_back(entry_reply(stack_mem[stack_count-1], 1'b1));
                    stack_count--;
                end
                REQ_PEEK:
                    got.push_back(entry_reply(stack_mem[stack_count-1], 1'b1));
                REQ_SEARCH:
                begin
                    hit = 1'b0;
                    for (k = stack_count - 1; k >= 0 && !hit; k--)
                    begin
                        if (stack_mem[k].name_low == w.key_name_low &&
                            stack_mem[k].name_mid == w.key_name_mid &&
                            stack_mem[k].name_high == w.key_name_high)
                        begin
                            got.push_back(entry_reply(stack_mem[k], 1'b1));
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                        got.push_back(status_reply(ST_NOTFOUND));
                end
                default:
                begin
                    for (k = stack_count - 1; k >= 0; k--)
                        got.push_back(entry_reply(stack_mem[k], k == 0));
                end
            endcase
        end
        if (keep)
            foreach (got[i])
                expected_replies.push_back(got[i]);
    endtask

    task automatic send_word(input rsws_in_t w);
        int gap;
        req <= w;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(0, 7);
        end
    endtask

    task automatic add_row(input rsws_in_t w, input int reps, input bit fresh,
                           input bit typed, input rsws_out_t reply);
        stim_row_t row;
        row.word = w;
        row.reps = reps;
        row.fresh = fresh;
        row.typed = typed;
        row.reply = reply;
        directed.push_back(row);
    endtask

    task automatic run_directed();
        rsws_in_t w;
        int r;
        add_row(make_req(REQ_POP, NAME_ZERO, 0, 0), 1, 0, 1, status_reply(ST_UNDER));
        add_row(make_req(REQ_PEEK, NAME_ZERO, 0, 0), 1, 0, 1, status_reply(ST_UNDER));
        add_row(make_req(REQ_SEARCH, NAME_ONES, 0, 0), 1, 0, 1, status_reply(ST_UNDER));
        add_row(make_req(REQ_LIST, NAME_ZERO, 0, 0), 1, 0, 1, status_reply(ST_UNDER));
        add_row(make_req(REQ_BAD_LO, NAME_ONES, '1, '1), 1, 0, 0, '0);
        add_row(make_req(REQ_BAD_HI, NAME_ONES, '1, '1), 1, 0, 0, '0);
        add_row(make_req(REQ_PUSH, NAME_ONES, 32'h8000_0000, 32'hffff_ffff), 1, 0, 1,
                status_reply(ST_OK));
        add_row(make_req(REQ_PUSH, NAME_ZERO, 32'h7fff_ffff, 32'h0), 1, 0, 1,
                status_reply(ST_OK));
        add_row(make_req(REQ_PUSH, NAME_GAP, 32'hffff_ffff, 32'h7f80_0000), 1, 0, 1,
                status_reply(ST_OK));
        add_row(make_req(REQ_SEARCH, NAME_ONES, 0, 0), 1, 0, 0, '0);
        add_row(make_req(REQ_SEARCH, NAME_GAP_ALT, 0, 0), 1, 0, 1, status_reply(ST_NOTFOUND));
        add_row(make_req(REQ_SEARCH, NAME_GAP_CUT, 0, 0), 1, 0, 1, status_reply(ST_NOTFOUND));
        add_row(make_req(REQ_SEARCH, NAME_ZERO, 0, 0), 1, 0, 0, '0);
        add_row(make_req(REQ_PEEK, NAME_ZERO, 0, 0), 1, 0, 0, '0);
        add_row(make_req(REQ_LIST, NAME_ZERO, 0, 0), 1, 0, 0, '0);
        add_row(make_req(REQ_POP, NAME_ZERO, 0, 0), 1, 0, 0, '0);
        add_row(make_req(REQ_PUSH, NAME_ONES, 32'h1, 32'h3f80_0000), 1, 0, 1,
                status_reply(ST_OK));
        add_row(make_req(REQ_SEARCH, NAME_ONES, 0, 0), 1, 0, 0, '0);
        add_row(make_req(REQ_PUSH, NAME_ZERO, 0, 0), DEPTH - 3, 1, 1, status_reply(ST_OK));
        add_row(make_req(REQ_PUSH, NAME_GAP, 0, 0), 1, 0, 1, status_reply(ST_OVER));
        add_row(make_req(REQ_LIST, NAME_ZERO, 0, 0), 1, 0, 0, '0);
        add_row(make_req(REQ_SEARCH, NAME_ZERO, 0, 0), 1, 0, 0, '0);
        add_row(make_req(REQ_POP, NAME_ZERO, 0, 0), 1, 0, 0, '0);
        foreach (directed[i])
        begin
            for (r = 0; r < directed[i].reps; r++)
            begin
                w = directed[i].word;
                if (directed[i].fresh)
                    w = make_req(w.req_type, random_name(), $urandom, $urandom);
                if (directed[i].typed)
                begin
                    predict_replies(w, 1'b0);
                    expected_replies.push_back(directed[i].reply);
                end
                else
                    predict_replies(w, 1'b1);
                send_word(w);
            end
        end
    endtask

    task automatic run_random();
        rsws_in_t     w;
        logic [2:0]   t;
        logic [159:0] n;
        mix_t         mix;
        int           mix_left;
        int           push_share;
        int           pick;
        int           counted;
        int           i;
        for (i = 0; i < 8; i++)
            name_pool[i] = random_name();
        name_pool[1] = name_pool[0] ^ {8'h80, 152'h0};
        mix = MIX_EVEN;
        mix_left = 0;
        counted = 0;
        while (counted < RANDOM_REQS)
        begin
            if (mix_left == 0)
            begin
                mix = mix_t'($urandom_range(0, 2));
                mix_left = $urandom_range(10, 30);
            end
            mix_left--;
            case (mix)
                MIX_FILL:  push_share = 60;
                MIX_DRAIN: push_share = 10;
                default:   push_share = 35;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 6)
                t = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
            else if (pick < 6 + push_share)
                t = REQ_PUSH;
            else
            begin
                pick = $urandom_range(0, 9);
                t = (pick < 3) ? REQ_POP : (pick < 6) ? REQ_SEARCH :
                    (pick < 8) ? REQ_PEEK : REQ_LIST;
            end
            n = ($urandom_range(0, 9) < 7) ? name_pool[$urandom_range(0, 7)] : random_name();
            w = make_req(t, n, $urandom, $urandom);
            if (t <= REQ_LIST)
                counted++;
            predict_replies(w, 1'b1);
            send_word(w);
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            replies_seen++;
            if (expected_replies.size() == 0)
            begin
                $display("%0t: reply with none pending, expected none, actual %p", $time, rsp);
                mismatches++;
            end
            else
            begin
                want = expected_replies.pop_front();
                check_field("status", 64'(want.status), 64'(rsp.status));
                check_field("out_name_low", want.out_name_low, rsp.out_name_low);
                check_field("out_name_mid", want.out_name_mid, rsp.out_name_mid);
                check_field("out_name_high", 64'(want.out_name_high), 64'(rsp.out_name_high));
                check_field("out_model", 64'(want.out_model), 64'(rsp.out_model));
                check_field("out_price_bits", 64'(want.out_price_bits),
                            64'(rsp.out_price_bits));
                check_field("last", 64'(want.last), 64'(rsp.last));
            end
        end
    end

    initial
    begin
        int  seg;
        int  stall;
        int  c;
        int  mode;
        bit  held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            // long hold-off so the block backs up its request side
            if (!held && replies_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            seg = $urandom_range(8, 40);
            mode = $urandom_range(0, 2);
            stall = $urandom_range(1, 6);
            for (c = 0; c < seg; c++)
            begin
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    default: rsp_ready <= (c % (stall + 1)) == stall;
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        req_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rsws_pkg.sv
hw/rtl/rsws_dp.sv
hw/rtl/rsws_ctrl.sv
hw/rtl/record_stack_with_search.sv
hw/rtl/rsws_checker.sv
dv/tb.sv
